>>> src/spi_mbe_pkg.sv
// spi_mbe_pkg: shared types and constants of the spi master bit engine
// no dependencies; imported by spi_master_bit_engine
package spi_mbe_pkg;

  // stream and configuration port widths, engine field widths and the default delay width
  localparam int unsigned InDataW          = 16;
  localparam int unsigned OutDataW         = 16;
  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned CfgDataW         = 16;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned BitIdxW          = 3;
  localparam int unsigned DefaultDelayBits = 16;

  // register reset values
  localparam logic [CfgDataW-1:0] HalfPeriodReset  = 16'd1;
  localparam logic [CfgDataW-1:0] ByteGapReset     = 16'd0;
  localparam logic                DriveSelectReset = 1'b1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_PERIOD  = 2'd0,
    CFG_BYTE_GAP     = 2'd1,
    CFG_DRIVE_SELECT = 2'd2
  } cfg_reg_e;

  // bit engine phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SEL_WAIT   = 3'd1,
    PH_LOW_WAIT   = 3'd2,
    PH_HIGH_WAIT  = 3'd3,
    PH_GAP        = 3'd4,
    PH_NEXT       = 3'd5,
    PH_DESEL_WAIT = 3'd6
  } phase_e;

endpackage

>>> src/spi_master_bit_engine.sv
// spi_master_bit_engine: mode 0, msb first spi master advanced one tick per item
// depends on spi_mbe_pkg
//
//  channel  | direction | contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one tick: start request, byte, last mark, pin levels
//  m_axis   | out       | pin levels, received byte, ready and done flags
//  cfg      | in        | register index and write data
//
// one item is accepted per cycle unless input stalls; its result is registered and shown the next cycle
// the result register parts the two sides: input stalls only while a result waits and m_axis_tready is low
// reset leaves the engine idle, select high, sclk and mosi low, registers at defaults
// configuration writes are always taken
module spi_master_bit_engine #(
  parameter int unsigned DELAY_BITS = spi_mbe_pkg::DefaultDelayBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // [0] start_req, [8:1] tx_byte, [9] miso_level, [10] select_level, rest zero
  input  logic [spi_mbe_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                              s_axis_tlast,   // last_byte
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] sclk, [1] mosi, [2] select_out, [3] rx_valid, [11:4] rx_byte,
  // [12] ready_res, [13] transfer_done, rest zero
  output logic [spi_mbe_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spi_mbe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spi_mbe_pkg::CfgDataW-1:0]  cfg_data_i
);
  import spi_mbe_pkg::*;

  localparam int unsigned CmpW = (DELAY_BITS > CfgDataW) ? DELAY_BITS : CfgDataW;
  localparam logic [CmpW-1:0] WaitMax = CmpW'({DELAY_BITS{1'b1}});

  // configuration registers
  logic [CfgDataW-1:0] half_period_q, byte_gap_q;
  logic                drive_sel_q;

  // engine state
  phase_e               phase_q, phase_d;
  logic [BitIdxW-1:0]   bit_idx_q, bit_idx_d;
  logic [DELAY_BITS-1:0] wait_q, wait_d;
  logic [ByteW-1:0]     tx_shift_q, tx_shift_d;
  logic [ByteW-1:0]     rx_shift_q, rx_shift_d;
  logic                 final_q, final_d;
  logic                 sclk_q, sclk_d;
  logic                 mosi_q, mosi_d;
  logic                 sel_q, sel_d;

  // result register
  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_data_q, m_data_d;

  // input fields
  logic             in_start, in_last, in_miso, in_sel, in_acc;
  logic [ByteW-1:0] in_byte;

  // saturated wait loads and per-tick results
  logic [DELAY_BITS-1:0] half_load, gap_load;
  logic                  rx_valid, done;
  logic [ByteW-1:0]      rx_byte;

  assign in_start = s_axis_tdata[0];
  assign in_byte  = s_axis_tdata[ByteW:1];
  assign in_miso  = s_axis_tdata[ByteW+1];
  assign in_sel   = s_axis_tdata[ByteW+2];
  assign in_last  = s_axis_tlast;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
      byte_gap_q    <= ByteGapReset;
      drive_sel_q   <= DriveSelectReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HALF_PERIOD:  half_period_q <= cfg_data_i;
        CFG_BYTE_GAP:     byte_gap_q    <= cfg_data_i;
        CFG_DRIVE_SELECT: drive_sel_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // wait loads saturate at the counter width
  always_comb begin
    half_load = (CmpW'(half_period_q) > WaitMax) ? DELAY_BITS'(WaitMax)
                                                 : DELAY_BITS'(CmpW'(half_period_q));
    gap_load  = (CmpW'(byte_gap_q) > WaitMax) ? DELAY_BITS'(WaitMax)
                                              : DELAY_BITS'(CmpW'(byte_gap_q));
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_idx_q  <= '0;
      wait_q     <= '0;
      tx_shift_q <= '0;
      rx_shift_q <= '0;
      final_q    <= 1'b0;
      sclk_q     <= 1'b0;
      mosi_q     <= 1'b0;
      sel_q      <= 1'b1;
      m_valid_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      bit_idx_q  <= bit_idx_d;
      wait_q     <= wait_d;
      tx_shift_q <= tx_shift_d;
      rx_shift_q <= rx_shift_d;
      final_q    <= final_d;
      sclk_q     <= sclk_d;
      mosi_q     <= mosi_d;
      sel_q      <= sel_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_data_q <= m_data_d;
    end
  end

  // next state for one tick
  always_comb begin
    phase_d    = phase_q;
    bit_idx_d  = bit_idx_q;
    wait_d     = wait_q;
    tx_shift_d = tx_shift_q;
    rx_shift_d = rx_shift_q;
    final_d    = final_q;
    sclk_d     = sclk_q;
    mosi_d     = mosi_q;
    sel_d      = sel_q;
    rx_valid   = 1'b0;
    rx_byte    = '0;
    done       = 1'b0;

    if (in_acc) begin
      unique case (phase_q)
        PH_SEL_WAIT: begin
          if (drive_sel_q || !in_sel) begin
            if (drive_sel_q) sel_d = 1'b0;
            sclk_d    = 1'b0;
            bit_idx_d = '0;
            mosi_d    = tx_shift_q[ByteW-1];
            wait_d    = half_load;
            phase_d   = PH_LOW_WAIT;
          end
        end
        PH_LOW_WAIT: begin
          if (wait_q != '0) begin
            wait_d = wait_q - DELAY_BITS'(1);
          end else begin
            sclk_d     = 1'b1;
            rx_shift_d = {rx_shift_q[ByteW-2:0], in_miso};
            wait_d     = half_load;
            phase_d    = PH_HIGH_WAIT;
          end
        end
        PH_HIGH_WAIT: begin
          if (wait_q != '0) begin
            wait_d = wait_q - DELAY_BITS'(1);
          end else begin
            sclk_d = 1'b0;
            if (bit_idx_q == '1) begin
              rx_valid = 1'b1;
              rx_byte  = rx_shift_q;
              wait_d   = gap_load;
              phase_d  = PH_GAP;
            end else begin
              bit_idx_d  = bit_idx_q + BitIdxW'(1);
              tx_shift_d = {tx_shift_q[ByteW-2:0], 1'b0};
              mosi_d     = tx_shift_q[ByteW-2];
              wait_d     = half_load;
              phase_d    = PH_LOW_WAIT;
            end
          end
        end
        PH_GAP: begin
          if (wait_q != '0) begin
            wait_d = wait_q - DELAY_BITS'(1);
          end else if (!final_q) begin
            phase_d = PH_NEXT;
          end else if (drive_sel_q || in_sel) begin
            sel_d   = 1'b1;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            phase_d = PH_DESEL_WAIT;
          end
        end
        PH_NEXT: begin
          if (in_start) begin
            tx_shift_d = in_byte;
            final_d    = in_last;
            if (drive_sel_q) sel_d = 1'b0;
            sclk_d     = 1'b0;
            bit_idx_d  = '0;
            mosi_d     = in_byte[ByteW-1];
            wait_d     = half_load;
            phase_d    = PH_LOW_WAIT;
          end
        end
        PH_DESEL_WAIT: begin
          if (drive_sel_q || in_sel) begin
            sel_d   = 1'b1;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
        default: begin
          // idle, and any code without meaning
          phase_d = PH_IDLE;
          if (in_start) begin
            tx_shift_d = in_byte;
            final_d    = in_last;
            if (drive_sel_q || !in_sel) begin
              if (drive_sel_q) sel_d = 1'b0;
              sclk_d    = 1'b0;
              bit_idx_d = '0;
              mosi_d    = in_byte[ByteW-1];
              wait_d    = half_load;
              phase_d   = PH_LOW_WAIT;
            end else begin
              phase_d = PH_SEL_WAIT;
            end
          end
        end
      endcase
    end

    // result item from the levels after this tick
    m_data_d = {{(OutDataW-ByteW-6){1'b0}}, done,
                (phase_d == PH_IDLE) || (phase_d == PH_NEXT),
                rx_byte, rx_valid, sel_d, mosi_d, sclk_d};

    // output register fills on accept and drains on take
    priority if (in_acc) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // sclk is high only through the high half of a bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sclk_q |-> (phase_q == PH_HIGH_WAIT))
    else $error("sclk high outside the high half period");

  // select is released whenever the engine is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> sel_q)
    else $error("select driven while idle");

  // the byte gap only follows the eighth bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GAP) |-> (bit_idx_q == '1))
    else $error("byte gap entered before the eighth bit");

  // every accepted item leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_valid_q)
    else $error("accepted item produced no result");

endmodule
